// ----- rtl/cdps_pkg.sv -----
// shared types, coefficient constants and curve tables for the color deficiency simulator
package cdps_pkg;

  // deficiency mode codes
  typedef enum logic [1:0] {
    MODE_PROTAN = 2'd0,
    MODE_DEUTAN = 2'd1,
    MODE_TRITAN = 2'd2,
    MODE_PASS   = 2'd3
  } mode_e;

  typedef logic [255:0][15:0] lut_t;
  typedef logic [383:0] big_t;

  localparam logic [1:0] ModeReset = MODE_DEUTAN;

  // forward matrix, linear rgb to lms, 20 fraction bits after the q4.12 input
  localparam logic [20:0] FWD_MAT [9] = '{
    21'd848924, 21'd1440386, 21'd159790,
    21'd317598, 21'd1497418, 21'd229857,
    21'd49023,  21'd163701,  21'd1198896
  };

  // inverse matrix, lms to linear rgb
  localparam logic signed [29:0] INV_MAT [9] = '{
    30'sd517255897, -30'sd500508964, 30'sd27019270,
    -30'sd108740989, 30'sd297218079, -30'sd42490682,
    -30'sd6303032,  -30'sd20116922,  30'sd239475398
  };

  // white point row sums per cone
  localparam logic [21:0] WHITE_SUM [3] = '{22'd2449100, 22'd2044873, 22'd1411620};

  // projection coefficients [mode][plane][ka, kb]
  localparam logic signed [26:0] PROJ_K [3][2][2] = '{
    '{'{27'sd22579536, -27'sd3600978}, '{27'sd22720696, -27'sd3805457}},
    '{'{27'sd12465931, 27'sd2675625},  '{27'sd12388481, 27'sd2809991}},
    '{'{-27'sd977962,  27'sd12752949}, '{-27'sd25153090, 27'sd41706968}}
  };

  localparam logic signed [22:0] LmsMax = 23'sd4194303;
  localparam logic signed [22:0] LmsMin = -23'sd4194304;

  // exact integer power, wide enough for a 16 bit base to the 21st
  function automatic big_t big_pow(logic [15:0] base, int e);
    big_t r;
    r = big_t'(1);
    for (int k = 0; k < e; k++) begin
      r = r * big_t'(base);
    end
    return r;
  endfunction

  // floor(4096 * v^(den/num)) by bitwise search
  function automatic logic [15:0] lin_one(logic [7:0] v, int num, int den);
    logic [15:0] x;
    logic [15:0] cand;
    big_t rhs;
    x = '0;
    rhs = big_pow({8'd0, v}, den) << (12 * num);
    for (int b = 15; b >= 0; b--) begin
      cand = x | (16'd1 << b);
      if (big_pow(cand, num) <= rhs) begin
        x = cand;
      end
    end
    return x;
  endfunction

  // smallest y with y^num >= c^den * 2^(12 num), threshold of output code c
  function automatic logic [15:0] thr_one(logic [7:0] c, int num, int den);
    logic [15:0] x;
    x = lin_one(c, num, den);
    if (big_pow(x, num) == (big_pow({8'd0, c}, den) << (12 * num))) begin
      return x;
    end
    return x + 16'd1;
  endfunction

  function automatic lut_t lin_table(int num, int den);
    lut_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = lin_one(8'(i), num, den);
    end
    return t;
  endfunction

  function automatic lut_t thr_table(int num, int den);
    lut_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = thr_one(8'(i), num, den);
    end
    return t;
  endfunction

  // input curves: exponent 1/2.1 for red and blue, 1/2 for green
  localparam lut_t LIN_RB = lin_table(21, 10);
  localparam lut_t LIN_G  = lin_table(2, 1);
  // output curve thresholds for exponents 2.1 and 2
  localparam lut_t THR_RB = thr_table(21, 10);
  localparam lut_t THR_G  = thr_table(2, 1);

endpackage

// ----- rtl/cdps_out_search.sv -----
// output power curve as an eight stage pipelined threshold search, three lanes
module cdps_out_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [15:0] y_i [3],
  output logic        valid_o,
  output logic [7:0]  code_o [3]
);

  logic        v_q [8];
  logic [15:0] y_q [8][3];
  logic [7:0]  c_q [8][3];

  for (genvar s = 0; s < 8; s++) begin : g_stage
    logic        v_in;
    logic [15:0] y_in [3];
    logic [7:0]  c_in [3];
    logic [7:0]  cand [3];
    logic [7:0]  c_d  [3];

    if (s == 0) begin : g_first
      assign v_in = valid_i;
      assign y_in = y_i;
      assign c_in = '{default: 8'd0};
    end else begin : g_next
      assign v_in = v_q[s-1];
      assign y_in = y_q[s-1];
      assign c_in = c_q[s-1];
    end

    // try the next lower bit of the code against its threshold
    always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
        cand[ch] = c_in[ch] | (8'd1 << (7 - s));
        if (ch == 1) begin
          c_d[ch] = (y_in[ch] >= cdps_pkg::THR_G[cand[ch]]) ? cand[ch] : c_in[ch];
        end else begin
          c_d[ch] = (y_in[ch] >= cdps_pkg::THR_RB[cand[ch]]) ? cand[ch] : c_in[ch];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        y_q[s] <= y_in;
        c_q[s] <= c_d;
      end
    end
  end

  assign valid_o = v_q[7];
  assign code_o  = c_q[7];

endmodule

// ----- rtl/color_deficiency_pixel_simulator.sv -----
// top level of the color deficiency pixel simulator pipeline
// One rgb pixel per clock enters unless the output stalls, and one simulated pixel
// leaves 15 register stages later (seven arithmetic stages, then an eight stage output
// curve search whose last register is the output register). Input curves are constant
// tables, the forward and inverse matrices run as registered multiplier banks, and the
// lost cone is rebuilt from a cross multiplied plane test. The whole pipe advances
// whenever the output register is empty or taken, so a stall holds every stage in place.
// deficiency_mode resets to deuteranopia; the user must write it with cfg_we_i only
// while the pipe is empty; the block does not enforce it. Code 3 passes pixels unprojected.
module color_deficiency_pixel_simulator #(
  parameter int OUT_INDEX_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,   // deficiency_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red_in, green_in, blue_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // red_out, green_out, blue_out
);

  localparam int Shift = 16 - OUT_INDEX_BITS;
  localparam logic [15:0] YMask = 16'(17'h0FFFF << Shift);

  logic [1:0] mode_q;
  logic       en;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cdps_pkg::ModeReset;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q;
    end
  end

  // stage 1: input curves
  logic [15:0] lin_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      lin_q[0] <= cdps_pkg::LIN_RB[s_axis_tdata[7:0]];
      lin_q[1] <= cdps_pkg::LIN_G[s_axis_tdata[15:8]];
      lin_q[2] <= cdps_pkg::LIN_RB[s_axis_tdata[23:16]];
    end
  end

  // stage 2: forward matrix products
  logic [36:0] fp_q [9];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        fp_q[k] <= 37'(cdps_pkg::FWD_MAT[k]) * 37'(lin_q[k % 3]);
      end
    end
  end

  // stage 3: row sums, lms stays below 2^18
  logic [38:0] fsum [3];
  logic [17:0] lms_q [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fsum[i] = 39'(fp_q[3*i]) + 39'(fp_q[3*i+1]) + 39'(fp_q[3*i+2]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        lms_q[i] <= fsum[i][37:20];
      end
    end
  end

  // stage 4: side test products and both planes' projection products
  logic [17:0]        cone_a, cone_b;
  logic [21:0]        wht_a, wht_b;
  logic signed [26:0] k_sel [2][2];
  logic signed [18:0] a_s, b_s;
  logic [39:0]        cross_a_q, cross_b_q;
  logic signed [45:0] pk_q [2][2];
  logic [17:0]        lms4_q [3];

  always_comb begin
    unique case (mode_q)
      cdps_pkg::MODE_PROTAN: begin
        cone_a = lms_q[1]; cone_b = lms_q[2];
        wht_a = cdps_pkg::WHITE_SUM[1]; wht_b = cdps_pkg::WHITE_SUM[2];
        k_sel = cdps_pkg::PROJ_K[0];
      end
      cdps_pkg::MODE_DEUTAN: begin
        cone_a = lms_q[0]; cone_b = lms_q[2];
        wht_a = cdps_pkg::WHITE_SUM[0]; wht_b = cdps_pkg::WHITE_SUM[2];
        k_sel = cdps_pkg::PROJ_K[1];
      end
      cdps_pkg::MODE_TRITAN: begin
        cone_a = lms_q[0]; cone_b = lms_q[1];
        wht_a = cdps_pkg::WHITE_SUM[0]; wht_b = cdps_pkg::WHITE_SUM[1];
        k_sel = cdps_pkg::PROJ_K[2];
      end
      default: begin
        cone_a = '0; cone_b = '0; wht_a = '0; wht_b = '0;
        k_sel = '{default: '{default: 27'sd0}};
      end
    endcase
    a_s = signed'({1'b0, cone_a});
    b_s = signed'({1'b0, cone_b});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cross_a_q <= 40'(cone_b) * 40'(wht_a);
      cross_b_q <= 40'(wht_b) * 40'(cone_a);
      for (int p = 0; p < 2; p++) begin
        pk_q[p][0] <= 46'(k_sel[p][0]) * 46'(a_s);
        pk_q[p][1] <= 46'(k_sel[p][1]) * 46'(b_s);
      end
      lms4_q <= lms_q;
    end
  end

  // stage 5: pick the plane, floor shift, saturate, replace the lost cone
  logic signed [46:0] psum, psh;
  logic signed [22:0] lost;
  logic signed [22:0] lms5_q [3];
  logic signed [22:0] lms5_d [3];

  always_comb begin
    // a zero cone_a fails the test and lands on the second plane
    if (cross_a_q < cross_b_q) begin
      psum = 47'(pk_q[0][0]) + 47'(pk_q[0][1]);
    end else begin
      psum = 47'(pk_q[1][0]) + 47'(pk_q[1][1]);
    end
    psh = psum >>> 24;
    if (psh > 47'(cdps_pkg::LmsMax)) begin
      lost = cdps_pkg::LmsMax;
    end else if (psh < 47'(cdps_pkg::LmsMin)) begin
      lost = cdps_pkg::LmsMin;
    end else begin
      lost = psh[22:0];
    end
    for (int i = 0; i < 3; i++) begin
      lms5_d[i] = signed'({5'd0, lms4_q[i]});
    end
    unique case (mode_q)
      cdps_pkg::MODE_PROTAN: lms5_d[0] = lost;
      cdps_pkg::MODE_DEUTAN: lms5_d[1] = lost;
      cdps_pkg::MODE_TRITAN: lms5_d[2] = lost;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lms5_q <= lms5_d;
    end
  end

  // stage 6: inverse matrix products
  logic signed [52:0] ip_q [9];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        ip_q[k] <= 53'(cdps_pkg::INV_MAT[k]) * 53'(lms5_q[k % 3]);
      end
    end
  end

  // stage 7: row sums, floor shift, clamp and quantize to the output table index
  logic signed [54:0] isum [3];
  logic signed [54:0] ish  [3];
  logic [15:0]        y_d  [3];
  logic [15:0]        y_q  [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      isum[i] = 55'(ip_q[3*i]) + 55'(ip_q[3*i+1]) + 55'(ip_q[3*i+2]);
      ish[i]  = isum[i] >>> 28;
      if (ish[i] < 55'sd0) begin
        y_d[i] = '0;
      end else if (ish[i] > 55'sd65535) begin
        y_d[i] = YMask;
      end else begin
        y_d[i] = ish[i][15:0] & YMask;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      y_q <= y_d;
    end
  end

  // stages 8 to 15: output curve
  logic [7:0] code [3];
  cdps_out_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .y_i     (y_q),
    .valid_o (m_axis_tvalid),
    .code_o  (code)
  );

  assign m_axis_tdata = {code[2], code[1], code[0]};

endmodule
